/* design/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// Used by the controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
   localparam int MaxBlocks   = 64;
   localparam int IdxW        = $clog2(MaxBlocks);
   localparam int CntW        = IdxW + 1;
   localparam int HeapBytes   = 65536;
   localparam int HeaderBytes = 32;
   localparam int RegW        = 17;
   localparam int SizeW       = 16;
   localparam logic [RegW-1:0] GrowChunkReset = 17'd256;
   localparam logic [RegW-1:0] HeapLimitReset = 17'd65536;
   localparam logic [RegW-1:0] HeapBytesC     = RegW'(HeapBytes);
   localparam logic [RegW-1:0] HeaderC        = RegW'(HeaderBytes);

   typedef enum logic [0:0] {
      CSR_GROW_CHUNK = 1'b0,
      CSR_HEAP_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_OOM   = 2'd1,
      ST_BADFR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_END, S_SHIFT_RD, S_SHIFT_WR,
      S_FINAL, S_FREE_NXT_RD, S_FREE_NXT, S_FREE_PRV_RD, S_FREE_PRV,
      S_RM_RD, S_RM_WR, S_DONE
   } state_type;

   // Command from controller to datapath
   typedef struct packed {
      logic scan_start;  // clear walk index and address
      logic rd;          // read entry at a chosen index
      logic [1:0] rd_sel; // 0 walk, 1 walk+1, 2 walk-1, 3 next shift source
      logic scan_adv;    // step walk to next entry
      logic grow;        // append chunk block
      logic split_setup; // begin an insert after walk
      logic shift_step;  // one move of an insert/remove shift
      logic split_fin;   // write split remainder and shrink walk entry
      logic mark_used;   // set walk entry used
      logic merge_next;  // free walk, absorb next, start remove of next
      logic merge_prev;  // absorb walk into prev, start remove of walk
      logic mark_free;   // clear used of walk entry
      logic rm_done;     // count down after remove
      logic set_result;
      logic [1:0] result_st;
   } cmd_type;

   typedef struct packed {
      logic walk_end;     // walk index == count
      logic hit_alloc;    // read entry fits
      logic hit_free;     // read entry header matches address
      logic rd_used;
      logic grow_ok;
      logic split_ok;
      logic shift_done;
      logic has_next;
      logic has_prev;
   } stat_type;
endpackage
`default_nettype wire

/* design/ffha_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output      logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* design/ffha_datapath.sv */
// Datapath: block table memory, walk counters, heap end and shift logic.
// Depends on ffha_pkg and ffha_ram.
`timescale 1ns / 1ps
`default_nettype none
module ffha_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ffha_pkg::cmd_type           cmd,
   output      ffha_pkg::stat_type          stat,
   input  wire logic                        req_load,
   input  wire logic [ffha_pkg::SizeW-1:0]  size_in,
   input  wire logic [ffha_pkg::SizeW-1:0]  addr_in,
   input  wire logic [ffha_pkg::RegW-1:0]   grow_chunk,
   input  wire logic [ffha_pkg::RegW-1:0]   heap_limit,
   output      logic [ffha_pkg::SizeW-1:0]  out_addr,
   output      logic [1:0]                  out_status
);
   import ffha_pkg::*;

   localparam int EntW = SizeW + 1;

   logic [CntW-1:0]  count_ff, count_in;
   logic [RegW-1:0]  heap_end_ff, heap_end_in;
   logic [CntW-1:0]  walk_ff, walk_in;
   logic [RegW+1:0]  addr_ff, addr_in_r;
   logic [CntW-1:0]  sh_ff, sh_in;
   logic             sh_ins_ff, sh_ins_in;
   logic [SizeW-1:0] size_ff, size_in_r;
   logic [SizeW-1:0] where_ff, where_in;
   logic [SizeW-1:0] hold_ff, hold_in;   // size of walk entry
   logic [SizeW-1:0] out_addr_ff, out_addr_in;
   logic [1:0]       out_st_ff, out_st_in;

   logic             we;
   logic [IdxW-1:0]  waddr, raddr;
   logic [EntW-1:0]  wdata, rdata;
   logic [CntW-1:0]  ridx;

   ffha_ram #(.Width(EntW), .Depth(MaxBlocks)) u_tab (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   logic [RegW-1:0] limit;
   logic [RegW:0]   grow_sum;
   logic [RegW-1:0] chunk_pay;
   logic [SizeW:0]  left;
   logic [RegW:0]   merged;

   always_comb begin
      limit     = (heap_limit < HeapBytesC) ? heap_limit : HeapBytesC;
      grow_sum  = {1'b0, heap_end_ff} + {1'b0, grow_chunk};
      chunk_pay = grow_chunk - HeaderC;
      left      = {1'b0, hold_ff} - {1'b0, size_ff};
      merged    = RegW'(hold_ff) + RegW'(rdata[SizeW-1:0]) + {1'b0, HeaderC};
   end

   // Status toward the controller
   always_comb begin
      stat.walk_end   = (walk_ff == count_ff);
      stat.hit_alloc  = !rdata[SizeW] && (rdata[SizeW-1:0] >= size_ff);
      stat.hit_free   = (addr_ff + (RegW+2)'(HeaderC)) == (RegW+2)'(where_ff);
      stat.rd_used    = rdata[SizeW];
      stat.grow_ok    = (grow_chunk > HeaderC) && ({1'b0, size_ff} <= chunk_pay)
                        && (count_ff < CntW'(MaxBlocks)) && (grow_sum <= {1'b0, limit});
      stat.split_ok   = (left > (SizeW+1)'(HeaderC)) && (count_ff < CntW'(MaxBlocks));
      stat.shift_done = sh_ins_ff ? (sh_ff == walk_ff + CntW'(1))
                                  : (sh_ff + CntW'(1) >= count_ff);
      stat.has_next   = (walk_ff + CntW'(1) < count_ff);
      stat.has_prev   = (walk_ff != '0);
   end

   // Read index selection
   always_comb begin
      case (cmd.rd_sel)
         2'd0:    ridx = walk_ff;
         2'd1:    ridx = walk_ff + CntW'(1);
         2'd2:    ridx = walk_ff - CntW'(1);
         default: ridx = sh_ins_ff ? sh_ff - CntW'(1) : sh_ff + CntW'(1);
      endcase
      raddr = ridx[IdxW-1:0];
   end

   // Next-state logic for counters and the table write port
   always_comb begin
      count_in    = count_ff;
      heap_end_in = heap_end_ff;
      walk_in     = walk_ff;
      addr_in_r   = addr_ff;
      sh_in       = sh_ff;
      sh_ins_in   = sh_ins_ff;
      size_in_r   = size_ff;
      where_in    = where_ff;
      hold_in     = hold_ff;
      out_addr_in = out_addr_ff;
      out_st_in   = out_st_ff;
      we          = 1'b0;
      waddr       = walk_ff[IdxW-1:0];
      wdata       = '0;
      if (req_load) begin
         size_in_r = size_in;
         where_in  = addr_in;
      end
      if (cmd.scan_start) begin
         walk_in   = '0;
         addr_in_r = '0;
      end
      if (cmd.scan_adv) begin
         walk_in   = walk_ff + CntW'(1);
         addr_in_r = addr_ff + (RegW+2)'(HeaderC) + (RegW+2)'(rdata[SizeW-1:0]);
      end
      if (cmd.rd && cmd.rd_sel == 2'd0) hold_in = rdata[SizeW-1:0];
      if (cmd.grow) begin
         we          = 1'b1;
         waddr       = count_ff[IdxW-1:0];
         wdata       = {1'b0, chunk_pay[SizeW-1:0]};
         hold_in     = chunk_pay[SizeW-1:0];
         addr_in_r   = (RegW+2)'(heap_end_ff);
         count_in    = count_ff + CntW'(1);
         heap_end_in = grow_sum[RegW-1:0];
      end
      if (cmd.split_setup) begin
         sh_in     = count_ff;
         sh_ins_in = 1'b1;
      end
      if (cmd.shift_step) begin
         we    = 1'b1;
         waddr = sh_ff[IdxW-1:0];
         wdata = rdata;
         sh_in = sh_ins_ff ? sh_ff - CntW'(1) : sh_ff + CntW'(1);
      end
      if (cmd.split_fin) begin
         we       = 1'b1;
         waddr    = sh_ff[IdxW-1:0];
         wdata    = {1'b0, left[SizeW-1:0] - SizeW'(HeaderBytes)};
         hold_in  = size_ff;
         count_in = count_ff + CntW'(1);
      end
      if (cmd.mark_used) begin
         we    = 1'b1;
         wdata = {1'b1, hold_ff};
      end
      if (cmd.mark_free) begin
         we    = 1'b1;
         wdata = {1'b0, hold_ff};
      end
      if (cmd.merge_next) begin
         we        = 1'b1;
         wdata     = {1'b0, merged[SizeW-1:0]};
         hold_in   = merged[SizeW-1:0];
         sh_in     = walk_ff + CntW'(1);
         sh_ins_in = 1'b0;
      end
      if (cmd.merge_prev) begin
         we        = 1'b1;
         waddr     = IdxW'(walk_ff - CntW'(1));
         wdata     = {1'b0, merged[SizeW-1:0]};
         sh_in     = walk_ff;
         sh_ins_in = 1'b0;
      end
      if (cmd.rm_done) count_in = count_ff - CntW'(1);
      if (cmd.set_result) begin
         out_st_in   = cmd.result_st;
         out_addr_in = (cmd.result_st == ST_OK)
                       ? SizeW'(addr_ff + (RegW+2)'(HeaderC)) : '0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         heap_end_ff <= '0;
         sh_ins_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         heap_end_ff <= heap_end_in;
         sh_ins_ff   <= sh_ins_in;
      end
      walk_ff     <= walk_in;
      addr_ff     <= addr_in_r;
      sh_ff       <= sh_in;
      size_ff     <= size_in_r;
      where_ff    <= where_in;
      hold_ff     <= hold_in;
      out_addr_ff <= out_addr_in;
      out_st_ff   <= out_st_in;
   end

   assign out_addr   = out_addr_ff;
   assign out_status = out_st_ff;

   // Table never holds more than its depth, and heap end never passes the heap size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxBlocks)) else $error("block count overflow");
   a_heap_range: assert property (@(posedge clock) disable iff (reset)
      heap_end_ff <= HeapBytesC) else $error("heap end overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.grow |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("growth did not add a block");
endmodule
`default_nettype wire

/* design/ffha_ctrl.sv */
// Controller state machine sequencing table walks, splits and merges.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_fire,
   input  wire logic               req_free,
   input  wire ffha_pkg::stat_type stat,
   output      ffha_pkg::cmd_type  cmd,
   output      logic               busy,
   output      logic               done
);
   import ffha_pkg::*;

   state_type state_ff, state_in;
   logic      free_ff, free_in;
   logic      prev_ff, prev_in;  // remove done is followed by previous merge check

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= 1'b0;
         prev_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         prev_ff  <= prev_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      free_in  = free_ff;
      prev_in  = prev_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               free_in        = req_free;
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.walk_end) begin
               if (free_ff) begin
                  cmd.set_result = 1'b1;
                  cmd.result_st  = ST_BADFR;
                  state_in       = S_DONE;
               end else if (stat.grow_ok) begin
                  cmd.grow = 1'b1;
                  state_in = S_ALLOC_END;
               end else begin
                  cmd.set_result = 1'b1;
                  cmd.result_st  = ST_OOM;
                  state_in       = S_DONE;
               end
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            cmd.rd = 1'b1;
            if (free_ff ? stat.hit_free : stat.hit_alloc) begin
               if (free_ff && !stat.rd_used) begin
                  cmd.set_result = 1'b1;
                  cmd.result_st  = ST_BADFR;
                  state_in       = S_DONE;
               end else begin
                  state_in = free_ff ? S_FREE_NXT_RD : S_ALLOC_END;
               end
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_ALLOC_END: begin
            if (stat.split_ok) begin
               cmd.split_setup = 1'b1;
               state_in        = S_SHIFT_RD;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_SHIFT_RD: begin
            cmd.rd_sel = 2'd3;
            if (stat.shift_done) begin
               if (free_ff) begin
                  cmd.rm_done = 1'b1;
                  state_in    = prev_ff ? S_FREE_PRV_RD : S_FINAL;
                  prev_in     = 1'b0;
               end else begin
                  cmd.split_fin = 1'b1;
                  state_in      = S_FINAL;
               end
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.rd_sel     = 2'd3;
            cmd.shift_step = 1'b1;
            state_in       = S_SHIFT_RD;
         end
         S_FINAL: begin
            if (!free_ff) cmd.mark_used = 1'b1;
            cmd.set_result = 1'b1;
            cmd.result_st  = ST_OK;
            state_in       = S_DONE;
         end
         S_FREE_NXT_RD: begin
            cmd.mark_free = 1'b1;
            cmd.rd_sel    = 2'd1;
            state_in      = S_FREE_NXT;
         end
         S_FREE_NXT: begin
            if (stat.has_next && !stat.rd_used) begin
               cmd.merge_next = 1'b1;
               prev_in        = 1'b1;
               state_in       = S_SHIFT_RD;
            end else begin
               state_in = S_FREE_PRV_RD;
            end
         end
         S_FREE_PRV_RD: begin
            cmd.rd_sel = 2'd2;
            state_in   = S_FREE_PRV;
         end
         S_FREE_PRV: begin
            if (stat.has_prev && !stat.rd_used) begin
               cmd.rd_sel     = 2'd2;
               cmd.merge_prev = 1'b1;
               state_in       = S_RM_RD;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_RM_RD: begin
            cmd.rd_sel = 2'd3;
            state_in   = S_SHIFT_RD;
         end
         S_DONE: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.grow, cmd.shift_step, cmd.split_fin, cmd.mark_used,
                  cmd.mark_free, cmd.merge_next, cmd.merge_prev}) <= 1)
      else $error("two table writes in one cycle");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == S_IDLE) else $error("done not followed by idle");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !busy) |=> state_ff == S_SCAN_RD) else $error("request not started");
endmodule
`default_nettype wire

/* design/first_fit_heap_allocator.sv */
// First-fit heap allocator top level: stream ports, config registers, result register.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
//
// Each request walks the block table stored in a 64-entry RAM with a registered
// read, reading and then checking each block visited; a split or merge then shifts
// the table one entry at a time, with a read state and a write state per entry.
// One request is handled at a time; the result register frees the walker once the
// result has been taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,  // req_size [15:0], free_addr [31:16]
   input  wire logic        req_tuser,  // action
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,  // payload_addr [15:0], status [17:16]
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [16:0] csr_data
);
   import ffha_pkg::*;

   logic [RegW-1:0] grow_chunk_ff, heap_limit_ff;
   logic            rsp_valid_ff;
   logic [SizeW-1:0] rsp_addr_ff;
   logic [1:0]      rsp_st_ff;
   logic            free_req_ff;
   cmd_type         cmd;
   stat_type        stat;
   logic            busy, done, req_fire;
   logic [SizeW-1:0] dp_addr;
   logic [1:0]      dp_st;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grow_chunk_ff <= GrowChunkReset;
         heap_limit_ff <= HeapLimitReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GROW_CHUNK: grow_chunk_ff <= csr_data;
            CSR_HEAP_LIMIT: heap_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ffha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_free(req_tuser),
      .stat(stat), .cmd(cmd), .busy(busy), .done(done)
   );

   ffha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_load(req_fire),
      .size_in(req_tdata[15:0]), .addr_in(req_tdata[31:16]),
      .grow_chunk(grow_chunk_ff), .heap_limit(heap_limit_ff),
      .out_addr(dp_addr), .out_status(dp_st)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (done) begin
         rsp_addr_ff <= (dp_st == ST_OK && !free_req_ff) ? dp_addr : '0;
         rsp_st_ff   <= dp_st;
      end
   end

   // Remember whether the request in progress is a free.
   always_ff @(posedge clock) begin
      if (req_fire) free_req_ff <= req_tuser;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_st_ff, rsp_addr_ff};

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff) else $error("result overwritten");
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
endmodule
`default_nettype wire

/* sim/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap allocator: drives allocate and free
// requests, predicts each result with a behavioral heap table, and checks every response.
// Depends on ffha_pkg and the first_fit_heap_allocator design.
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int Period = 4;

   typedef struct packed {
      logic        action;
      logic [15:0] req_size;
      logic [15:0] free_addr;
   } heap_request_t;

   typedef struct packed {
      logic [15:0] payload_addr;
      status_type  status;
   } heap_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [16:0] csr_data = '0;

   first_fit_heap_allocator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #(Period / 2) clock = ~clock;

   // Shadow heap table and registers.
   int unsigned  blk_size [MaxBlocks];
   bit           blk_used [MaxBlocks];
   int unsigned  blk_count;
   int unsigned  heap_top;
   int unsigned  chunk_bytes;
   int unsigned  limit_bytes;

   heap_request_t pending_requests[$];
   heap_result_t  expected_results[$];
   int            mismatches = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            recv_hold = 0;
   int            sent_count = 0;
   int            checked_count = 0;
   int            oom_count = 0;
   int            badfree_count = 0;

   // Live allocations, so frees mostly target real blocks.
   int unsigned   live_addrs[$];

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic void table_insert(input int unsigned pos, input int unsigned size);
      for (int unsigned k = blk_count; k > pos; k--) begin
         blk_size[k] = blk_size[k-1];
         blk_used[k] = blk_used[k-1];
      end
      blk_size[pos] = size;
      blk_used[pos] = 1'b0;
      blk_count++;
   endfunction

   function automatic void table_remove(input int unsigned pos);
      for (int unsigned k = pos; k + 1 < blk_count; k++) begin
         blk_size[k] = blk_size[k+1];
         blk_used[k] = blk_used[k+1];
      end
      blk_count--;
   endfunction

   // Computes the result of one request and updates the shadow heap.
   function automatic heap_result_t heap_predict(input heap_request_t rq);
      heap_result_t res;
      int unsigned  i;
      int unsigned  addr;
      int unsigned  lim;
      res.payload_addr = '0;
      res.status = ST_OK;
      addr = 0;
      if (!rq.action) begin
         for (i = 0; i < blk_count; i++) begin
            if (!blk_used[i] && blk_size[i] >= rq.req_size) break;
            addr += HeaderBytes + blk_size[i];
         end
         if (i == blk_count) begin
            lim = (limit_bytes < HeapBytes) ? limit_bytes : HeapBytes;
            if (chunk_bytes <= HeaderBytes || rq.req_size > chunk_bytes - HeaderBytes ||
                blk_count >= MaxBlocks || heap_top + chunk_bytes > lim) begin
               res.status = ST_OOM;
               return res;
            end
            addr = heap_top;
            table_insert(blk_count, chunk_bytes - HeaderBytes);
            heap_top += chunk_bytes;
         end
         if (blk_size[i] - rq.req_size > HeaderBytes && blk_count < MaxBlocks) begin
            table_insert(i + 1, blk_size[i] - rq.req_size - HeaderBytes);
            blk_size[i] = rq.req_size;
         end
         blk_used[i] = 1'b1;
         res.payload_addr = 16'(addr + HeaderBytes);
      end else begin
         for (i = 0; i < blk_count; i++) begin
            if (addr + HeaderBytes == rq.free_addr) break;
            addr += HeaderBytes + blk_size[i];
         end
         if (i == blk_count || !blk_used[i]) begin
            res.status = ST_BADFR;
            return res;
         end
         blk_used[i] = 1'b0;
         if (i + 1 < blk_count && !blk_used[i+1]) begin
            blk_size[i] += blk_size[i+1] + HeaderBytes;
            table_remove(i + 1);
         end
         if (i > 0 && !blk_used[i-1]) begin
            blk_size[i-1] += blk_size[i] + HeaderBytes;
            table_remove(i);
         end
      end
      return res;
   endfunction

   // Queues one request and keeps the list of live payload offsets current.
   task automatic queue_request(input logic act, input int unsigned size,
                                input int unsigned addr);
      heap_request_t rq;
      heap_result_t  res;
      rq.action = act;
      rq.req_size = 16'(size);
      rq.free_addr = 16'(addr);
      res = heap_predict(rq);
      pending_requests.push_back(rq);
      expected_results.push_back(res);
      if (!act && res.status == ST_OK) live_addrs.push_back(res.payload_addr);
      if (act && res.status == ST_OK)
         foreach (live_addrs[j])
            if (live_addrs[j] == addr) begin
               live_addrs.delete(j);
               break;
            end
   endtask

   function automatic int unsigned pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 96);
      if (r < 90) return $urandom_range(0, chunk_bytes > 32 ? chunk_bytes - 32 : 0);
      return $urandom_range(0, 65535);
   endfunction

   task automatic queue_random(input int count);
      int unsigned r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            queue_request(1'b0, pick_size(), $urandom_range(0, 65535));
         else if (r < 88 && live_addrs.size() > 0)
            queue_request(1'b1, $urandom_range(0, 65535),
                          live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
         else
            queue_request(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      // A free with no result pending may still be merging; allow the full walk time.
      repeat (300) @(posedge clock);
   endtask

   // Writes one register through the configuration channel while the block is idle.
   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 17'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_GROW_CHUNK) chunk_bytes = value & 17'h1FFFF;
      else limit_bytes = value & 17'h1FFFF;
   endtask

   // Driver: offers the oldest pending request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) void'(pending_requests.pop_front());
         if ((!req_tvalid || req_tready) && pending_requests.size() > 0) begin
            if ($urandom_range(0, 99) < send_idle_pct) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_requests[0].action;
               req_tdata  <= {pending_requests[0].free_addr, pending_requests[0].req_size};
            end
         end else if (req_tvalid && req_tready) begin
            req_tvalid <= 1'b0;
         end
         if (req_tvalid && req_tready) sent_count++;
      end
   end

   // Monitor: checks each accepted response and drives the ready side.
   always @(posedge clock) begin
      heap_result_t got;
      heap_result_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.payload_addr = rsp_tdata[15:0];
            got.status = status_type'(rsp_tdata[17:16]);
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response, payload_addr", got.payload_addr, 0);
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (want.status == ST_OOM) oom_count++;
               if (want.status == ST_BADFR) badfree_count++;
               if (got.payload_addr !== want.payload_addr)
                  report_mismatch("payload_addr", got.payload_addr, want.payload_addr);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
         if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Stimulus.
   initial begin
      blk_count = 0;
      heap_top = 0;
      chunk_bytes = GrowChunkReset;
      limit_bytes = HeapLimitReset;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero-size, exact fit, split, chunk-size extremes and bad frees.
      queue_request(1'b1, 0, 32);        // free on an empty heap
      queue_request(1'b0, 0, 0);         // zero-size allocate grows and splits
      queue_request(1'b0, 224, 0);       // exact fit of a chunk
      queue_request(1'b0, 225, 0);       // larger than a chunk
      queue_request(1'b0, 65535, 65535);
      queue_request(1'b1, 0, 65535);     // not a block offset
      queue_request(1'b1, 0, 32);
      queue_request(1'b1, 0, 32);        // already free
      queue_request(1'b0, 100, 0);
      queue_request(1'b0, 40, 0);
      queue_request(1'b0, 10, 0);
      if (live_addrs.size() > 1) queue_request(1'b1, 0, live_addrs[1]);
      if (live_addrs.size() > 0) queue_request(1'b1, 0, live_addrs[0]);
      wait_drained();

      // Small chunk and tight limit, then chunk too small to grow.
      write_csr(CSR_GROW_CHUNK, 33);
      write_csr(CSR_HEAP_LIMIT, heap_top + 66);
      queue_request(1'b0, 1, 0);
      queue_request(1'b0, 0, 0);
      queue_request(1'b0, 2, 0);
      queue_request(1'b0, 0, 0);
      queue_request(1'b0, 0, 0);        // limit reached
      wait_drained();
      write_csr(CSR_GROW_CHUNK, 32);
      write_csr(CSR_HEAP_LIMIT, 0);
      queue_request(1'b0, 0, 0);
      queue_request(1'b0, 65535, 0);
      wait_drained();

      // Random phase one: sender idles 25, receiver 88; with a long receiver hold.
      write_csr(CSR_GROW_CHUNK, 65536);
      write_csr(CSR_HEAP_LIMIT, 65536);
      send_idle_pct = 25;
      recv_idle_pct = 88;
      recv_hold = 600;
      queue_random(200);
      wait_drained();

      // Random phase two: roles swapped, smaller chunks fill the table.
      write_csr(CSR_GROW_CHUNK, 512);
      write_csr(CSR_HEAP_LIMIT, 30000);
      send_idle_pct = 88;
      recv_idle_pct = 25;
      queue_random(200);
      wait_drained();

      // Random phase three: no idling, default-like settings, many blocks.
      write_csr(CSR_GROW_CHUNK, 256);
      write_csr(CSR_HEAP_LIMIT, 131071);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(220);
      wait_drained();

      $display("Sent %0d requests, checked %0d responses (%0d out-of-memory, %0d bad frees).",
               sent_count, checked_count, oom_count, badfree_count);
      $display("Covered several chunk and limit settings with idle, stall and hold-off phases.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(3_000_000 * Period);
      $display("Timeout with %0d responses outstanding.", expected_results.size());
      $display("Test completed with failures");
      $finish;
   end
endmodule
